FILE: src/rrs_pkg.sv
// Shared types and constants of the rotated region sampler.
package rrs_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;
    localparam int REGION_MAX  = 256;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_CENTER_X      = 3'd2,
        CFG_CENTER_Y      = 3'd3,
        CFG_REGION_WIDTH  = 3'd4,
        CFG_REGION_HEIGHT = 3'd5,
        CFG_COS_FACTOR    = 3'd6,
        CFG_SIN_FACTOR    = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic        [8:0]  image_width;
        logic        [8:0]  image_height;
        logic signed [9:0]  center_x;
        logic signed [9:0]  center_y;
        logic        [8:0]  region_width;
        logic        [8:0]  region_height;
        logic signed [15:0] cos_factor;
        logic signed [15:0] sin_factor;
    } t_cfg;

    // One queued job: a pixel write, or a sample with its region offsets.
    typedef struct packed {
        t_opcode            op;
        logic        [15:0] pixel_index;
        logic        [7:0]  pixel_value;
        logic signed [9:0]  col_off;
        logic signed [9:0]  row_off;
        logic               last;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

FILE: src/rrs_in_if.sv
// Input channel: pixel writes and sample requests.
interface rrs_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [15:0] pixel_index;
    logic [7:0]  pixel_value;

    modport source (output valid, output opcode, output pixel_index, output pixel_value,
                    input ready);
    modport sink   (input valid, input opcode, input pixel_index, input pixel_value,
                    output ready);
endinterface

FILE: src/rrs_out_if.sv
// Output channel: sampled region pixels.
interface rrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_value;
    logic       outside;
    logic       last;

    modport source (output valid, output sample_value, output outside, output last,
                    input ready);
    modport sink   (input valid, input sample_value, input outside, input last,
                    output ready);
endinterface

FILE: src/rotated_region_sampler_top.sv
// Top level of the rotated region sampler.
// Usage:
//   i_in carries words with valid/ready. Opcode OP_WRITE stores pixel_value at
//   raster address pixel_index; opcode OP_SAMPLE asks for the next pixel of the
//   tilted region, row outer and column inner. Writes give no output word.
//   o_out carries one word per sample: the pixel (0 when the rotated source
//   position lies off the image), the outside flag and the last-of-region flag.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); the user
//   must write it only while no item is in flight, which the block does not enforce.
// Pipeline and throughput:
//   After the queue a sample passes a job register, product, sum, round, position check,
//   address multiply, store read and output register. One word is accepted per cycle
//   while o_out drains; the pixel store read and write share one pipeline stage.
// Reset and stall:
//   Reset clears the region counters, the queue and all stage valids and
//   loads default configuration; pixel store contents stay undefined.
//   When the receiver stalls, the pipeline holds, the four-entry queue fills,
//   and then i_in.ready drops.
module rotated_region_sampler_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rrs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [rrs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    rrs_in_if.sink                              i_in,
    rrs_out_if.source                           o_out
);
    rrs_pkg::t_cfg      r_cfg;
    rrs_pkg::t_q_status q_status;
    rrs_pkg::t_job      push_job;
    rrs_pkg::t_job      head_job;
    logic               q_push;
    logic               q_pop;

    // Configuration registers; advance only on a write enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= 9'd256;
            r_cfg.image_height  <= 9'd256;
            r_cfg.center_x      <= 10'sd0;
            r_cfg.center_y      <= 10'sd0;
            r_cfg.region_width  <= 9'd64;
            r_cfg.region_height <= 9'd64;
            r_cfg.cos_factor    <= 16'sd16384;
            r_cfg.sin_factor    <= 16'sd0;
        end else if (i_cfg_we) begin
            case (rrs_pkg::t_cfg_index'(i_cfg_index))
                rrs_pkg::CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[8:0];
                rrs_pkg::CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data[8:0];
                rrs_pkg::CFG_CENTER_X:      r_cfg.center_x      <= $signed(i_cfg_data[9:0]);
                rrs_pkg::CFG_CENTER_Y:      r_cfg.center_y      <= $signed(i_cfg_data[9:0]);
                rrs_pkg::CFG_REGION_WIDTH:  r_cfg.region_width  <= i_cfg_data[8:0];
                rrs_pkg::CFG_REGION_HEIGHT: r_cfg.region_height <= i_cfg_data[8:0];
                rrs_pkg::CFG_COS_FACTOR:    r_cfg.cos_factor    <= $signed(i_cfg_data);
                rrs_pkg::CFG_SIN_FACTOR:    r_cfg.sin_factor    <= $signed(i_cfg_data);
                default:                    r_cfg               <= r_cfg;
            endcase
        end
    end

    // Front end classifies words and stamps samples with region offsets.
    rrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_in       (i_in),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    // Decouple acceptance from the sampling pipeline.
    rrs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (push_job),
        .i_pop    (q_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // Back end rotates, checks bounds and reads or writes the pixel store.
    rrs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_status.full))
        else $error("queue push while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_status.empty))
        else $error("queue pop while empty");

    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready && !q_push) |=> $stable(q_status.count))
        else $error("queue drained while output stalled");
`endif
endmodule

FILE: src/rrs_front.sv
// Front end: accept words, track the region raster position, build jobs.
module rrs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrs_pkg::t_cfg      i_cfg,
    input  rrs_pkg::t_q_status i_q_status,
    rrs_in_if.sink             i_in,
    output logic               o_push,
    output rrs_pkg::t_job      o_job
);
    logic [7:0] r_col;
    logic [7:0] r_row;
    logic [7:0] n_col;
    logic [7:0] n_row;
    logic [8:0] rw;
    logic [8:0] rh;
    logic       col_end;
    logic       row_end;
    logic       is_sample;

    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;
    assign is_sample  = rrs_pkg::t_opcode'(i_in.opcode) == rrs_pkg::OP_SAMPLE;

    // Zero size reads as one, anything above the region limit as the limit.
    always_comb begin
        if (i_cfg.region_width == 9'd0) begin
            rw = 9'd1;
        end else if (32'(i_cfg.region_width) > rrs_pkg::REGION_MAX) begin
            rw = 9'(rrs_pkg::REGION_MAX);
        end else begin
            rw = i_cfg.region_width;
        end
        if (i_cfg.region_height == 9'd0) begin
            rh = 9'd1;
        end else if (32'(i_cfg.region_height) > rrs_pkg::REGION_MAX) begin
            rh = 9'(rrs_pkg::REGION_MAX);
        end else begin
            rh = i_cfg.region_height;
        end
    end

    // A counter at or past its last index ends the row or region.
    assign col_end = ({1'b0, r_col} + 9'd1) >= rw;
    assign row_end = ({1'b0, r_row} + 9'd1) >= rh;

    always_comb begin
        if (col_end) begin
            n_col = 8'd0;
            n_row = row_end ? 8'd0 : r_row + 8'd1;
        end else begin
            n_col = r_col + 8'd1;
            n_row = r_row;
        end
    end

    always_comb begin
        o_job.op          = rrs_pkg::t_opcode'(i_in.opcode);
        o_job.pixel_index = i_in.pixel_index;
        o_job.pixel_value = i_in.pixel_value;
        o_job.col_off     = $signed({2'b00, r_col}) - $signed({2'b00, rw[8:1]});
        o_job.row_off     = $signed({2'b00, r_row}) - $signed({2'b00, rh[8:1]});
        o_job.last        = col_end && row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
        end else if (o_push && is_sample) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end
endmodule

FILE: src/rrs_queue.sv
// Short job queue between the front end and the sampling pipeline.
module rrs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rrs_pkg::t_job      i_job,
    input  logic               i_pop,
    output rrs_pkg::t_job      o_job,
    output rrs_pkg::t_q_status o_status
);
    rrs_pkg::t_job                r_slot [rrs_pkg::Q_DEPTH];
    logic [rrs_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [rrs_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [rrs_pkg::Q_CNT_W-1:0] r_count;

    assign o_job           = r_slot[r_rd_ptr];
    assign o_status.full   = r_count == rrs_pkg::Q_CNT_W'(rrs_pkg::Q_DEPTH);
    assign o_status.empty  = r_count == '0;
    assign o_status.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

FILE: src/rrs_back.sv
// Back end: rotate offsets, bound check, access the pixel store, emit samples.
module rrs_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrs_pkg::t_cfg      i_cfg,
    input  rrs_pkg::t_q_status i_q_status,
    input  rrs_pkg::t_job      i_job,
    output logic               o_pop,
    rrs_out_if.source          o_out
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [PIXEL_BITS-1:0] r_store [DEPTH];

    logic advance;

    // Product stage.
    logic                 r_p_v;
    rrs_pkg::t_job        r_p_job;
    // Sum stage.
    logic                 r_d_v;
    rrs_pkg::t_job        r_d_job;
    logic signed [25:0]   r_d_ci, r_d_sj, r_d_si, r_d_cj;
    // Round stage.
    logic                 r_r_v;
    rrs_pkg::t_job        r_r_job;
    logic signed [26:0]   r_r_dx, r_r_dy;
    // Position stage.
    logic                 r_x_v;
    rrs_pkg::t_job        r_x_job;
    logic signed [12:0]   r_x_rx, r_x_ry;
    // Address stage.
    logic                 r_a_v;
    rrs_pkg::t_job        r_a_job;
    logic [8:0]           r_a_x, r_a_y;
    logic                 r_a_outside;
    // Memory stage.
    logic                 r_m_v;
    rrs_pkg::t_job        r_m_job;
    logic [17:0]          r_m_addr;
    logic                 r_m_outside;
    // Read data stage.
    logic                 r_q_v;
    logic                 r_q_outside;
    logic                 r_q_last;
    logic [PIXEL_BITS-1:0] r_q_pix;
    // Output register.
    logic                 r_out_v;
    logic [7:0]           r_out_sample;
    logic                 r_out_outside;
    logic                 r_out_last;

    logic signed [26:0]   bias_x, bias_y, sum_bx, sum_by;
    logic signed [13:0]   pos_x, pos_y;
    logic [8:0]           img_w, img_h;
    logic                 n_outside;
    logic                 wr_en;

    // Hold every stage while the output word waits.
    assign advance = !r_out_v || o_out.ready;
    assign o_pop   = advance && !i_q_status.empty;

    always_comb begin
        img_w = (32'(i_cfg.image_width)  > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : i_cfg.image_width;
        img_h = (32'(i_cfg.image_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : i_cfg.image_height;
    end

    // Round half away from zero: a negative sum takes one less of the half.
    assign bias_x = r_r_dx[26] ? 27'sd8191 : 27'sd8192;
    assign bias_y = r_r_dy[26] ? 27'sd8191 : 27'sd8192;
    assign sum_bx = r_r_dx + bias_x;
    assign sum_by = r_r_dy + bias_y;

    assign pos_x = 14'(r_x_rx) + 14'(i_cfg.center_x);
    assign pos_y = 14'(r_x_ry) + 14'(i_cfg.center_y);
    assign n_outside = pos_x[13] || pos_y[13] ||
                       (pos_x >= $signed({5'b00000, img_w})) ||
                       (pos_y >= $signed({5'b00000, img_h}));

    assign wr_en = advance && r_m_v && (r_m_job.op == rrs_pkg::OP_WRITE) &&
                   (32'(r_m_job.pixel_index) < DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_r_v   <= 1'b0;
            r_x_v   <= 1'b0;
            r_a_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_q_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_p_v   <= !i_q_status.empty;
            r_d_v   <= r_p_v;
            r_r_v   <= r_d_v;
            r_x_v   <= r_r_v;
            r_a_v   <= r_x_v;
            r_m_v   <= r_a_v;
            r_q_v   <= r_m_v && (r_m_job.op == rrs_pkg::OP_SAMPLE);
            r_out_v <= r_q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_p_job <= i_job;

            r_d_job <= r_p_job;
            r_d_ci  <= i_cfg.cos_factor * r_p_job.col_off;
            r_d_sj  <= i_cfg.sin_factor * r_p_job.row_off;
            r_d_si  <= i_cfg.sin_factor * r_p_job.col_off;
            r_d_cj  <= i_cfg.cos_factor * r_p_job.row_off;

            r_r_job <= r_d_job;
            r_r_dx  <= 27'(r_d_ci) - 27'(r_d_sj);
            r_r_dy  <= 27'(r_d_si) + 27'(r_d_cj);

            r_x_job <= r_r_job;
            r_x_rx  <= $signed(sum_bx[26:rrs_pkg::FRAC_BITS]);
            r_x_ry  <= $signed(sum_by[26:rrs_pkg::FRAC_BITS]);

            r_a_job     <= r_x_job;
            r_a_x       <= pos_x[8:0];
            r_a_y       <= pos_y[8:0];
            r_a_outside <= n_outside;

            r_m_job     <= r_a_job;
            r_m_addr    <= 18'(r_a_y * img_w) + 18'(r_a_x);
            r_m_outside <= r_a_outside;

            r_q_outside <= r_m_outside;
            r_q_last    <= r_m_job.last;

            r_out_sample  <= r_q_outside ? 8'd0 : 8'(r_q_pix);
            r_out_outside <= r_q_outside;
            r_out_last    <= r_q_last;
        end
    end

    // Pixel store: writes and reads meet at one stage, so they stay in order.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[AW'(r_m_job.pixel_index)] <= PIXEL_BITS'(r_m_job.pixel_value);
        end
        if (advance) begin
            r_q_pix <= r_store[AW'(r_m_addr)];
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.sample_value = r_out_sample;
    assign o_out.outside      = r_out_outside;
    assign o_out.last         = r_out_last;
endmodule

FILE: sim/rotated_region_sampler_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rotated region sampler: predicts each region pixel and compares.
module rotated_region_sampler_top_tb;

    localparam int     MAX_W         = 256;
    localparam int     MAX_H         = 256;
    localparam int     STORE_SIZE    = MAX_W * MAX_H;
    localparam int     CLK_HALF      = 10;
    localparam int     SETTLE_CYCLES = 12;   // covers the eight-stage path plus margin
    localparam int     RANDOM_WORDS  = 1900;
    localparam longint TIMEOUT_NS    = 10_000_000;

    // One expected output word.
    typedef struct packed {
        logic [7:0] value;
        logic       outside;
        logic       last;
    } t_sample;

    // Where the next sample word lands in the source image, and how it ends.
    typedef struct {
        bit          in_image;
        int unsigned addr;
        bit          col_end;
        bit          row_end;
    } t_source;

    // Shadow of the sampler: pixel store, registers, region counters and the words owed.
    class rotation_checker;
        logic [7:0]         pixels [STORE_SIZE];
        bit                 written [STORE_SIZE];
        logic [8:0]         img_w, img_h, reg_w, reg_h;
        logic signed [9:0]  ctr_x, ctr_y;
        logic signed [15:0] cos_q, sin_q;
        logic [7:0]         col_cnt, row_cnt;
        t_sample            pending_samples [$];
        int                 mismatch_count;

        function new();
            img_w          = 9'd256;
            img_h          = 9'd256;
            ctr_x          = '0;
            ctr_y          = '0;
            reg_w          = 9'd64;
            reg_h          = 9'd64;
            cos_q          = 16'sd16384;
            sin_q          = '0;
            col_cnt        = '0;
            row_cnt        = '0;
            mismatch_count = 0;
        endfunction

        function void set_reg(rrs_pkg::t_cfg_index idx, logic [15:0] d);
            case (idx)
                rrs_pkg::CFG_IMAGE_WIDTH:   img_w = d[8:0];
                rrs_pkg::CFG_IMAGE_HEIGHT:  img_h = d[8:0];
                rrs_pkg::CFG_CENTER_X:      ctr_x = d[9:0];
                rrs_pkg::CFG_CENTER_Y:      ctr_y = d[9:0];
                rrs_pkg::CFG_REGION_WIDTH:  reg_w = d[8:0];
                rrs_pkg::CFG_REGION_HEIGHT: reg_h = d[8:0];
                rrs_pkg::CFG_COS_FACTOR:    cos_q = d;
                rrs_pkg::CFG_SIN_FACTOR:    sin_q = d;
                default: ;
            endcase
        endfunction

        // Zero counts as one, anything past the counter range as the full range.
        function int region_dim(logic [8:0] v);
            if (v == 9'd0) return 1;
            return (v > rrs_pkg::REGION_MAX) ? rrs_pkg::REGION_MAX : int'(v);
        endfunction

        // Round a Q14 sum to an integer, halves away from zero.
        function longint round_q14(longint v);
            longint half;
            half = longint'(1) <<< (rrs_pkg::FRAC_BITS - 1);
            if (v >= 0) return (v + half) >>> rrs_pkg::FRAC_BITS;
            return -((half - v) >>> rrs_pkg::FRAC_BITS);
        endfunction

        function t_source trace_source();
            t_source src;
            longint  w, h, rw, rh, i, j, x, y;
            w  = (img_w > MAX_W) ? MAX_W : img_w;
            h  = (img_h > MAX_H) ? MAX_H : img_h;
            rw = region_dim(reg_w);
            rh = region_dim(reg_h);
            i  = longint'(col_cnt) - rw / 2;
            j  = longint'(row_cnt) - rh / 2;
            x  = round_q14(longint'(cos_q) * i - longint'(sin_q) * j) + longint'(ctr_x);
            y  = round_q14(longint'(sin_q) * i + longint'(cos_q) * j) + longint'(ctr_y);
            src.in_image = (x >= 0) && (x < w) && (y >= 0) && (y < h);
            src.addr     = src.in_image ? int'(y * w + x) : 0;
            // A counter left past a shrunken size still ends its row or the region.
            src.col_end  = longint'(col_cnt) + 1 >= rw;
            src.row_end  = longint'(row_cnt) + 1 >= rh;
            return src;
        endfunction

        function void take_input(rrs_pkg::t_opcode op, logic [15:0] idx, logic [7:0] val);
            t_source src;
            t_sample want;
            if (op == rrs_pkg::OP_WRITE) begin
                pixels[idx]  = val;
                written[idx] = 1'b1;
                return;
            end
            src          = trace_source();
            want.value   = src.in_image ? pixels[src.addr] : 8'd0;
            want.outside = !src.in_image;
            want.last    = src.col_end && src.row_end;
            pending_samples.push_back(want);
            if (src.col_end) begin
                col_cnt = 8'd0;
                row_cnt = src.row_end ? 8'd0 : row_cnt + 8'd1;
            end else begin
                col_cnt = col_cnt + 8'd1;
            end
        endfunction

        task report(string what);
            mismatch_count++;
            $display("[%0t] sample check: %s", $time, what);
        endtask

        task check_sample(logic [7:0] value, logic outside, logic last);
            t_sample want;
            if (pending_samples.size() == 0) begin
                report($sformatf("word with nothing owed: value=%0h outside=%0b last=%0b",
                                 value, outside, last));
                return;
            end
            want = pending_samples.pop_front();
            if (value !== want.value)
                report($sformatf("sample_value %0h, want %0h", value, want.value));
            if (outside !== want.outside)
                report($sformatf("outside %0b, want %0b", outside, want.outside));
            if (last !== want.last)
                report($sformatf("last %0b, want %0b", last, want.last));
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [rrs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rrs_pkg::CFG_DATA_W-1:0]  cfg_data;

    rrs_in_if  in_if ();
    rrs_out_if out_if ();

    rotation_checker board;
    int              words_sent;
    int              src_calm;   // words left in a no-gap stretch on the input side
    int              snk_calm;   // same for the output side

    rotated_region_sampler_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .PIXEL_BITS (8)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Draw the idle cycles before the next word; now and then open a stretch with no idling.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) calm = $urandom_range(8, 48);
        return $urandom_range(0, 13);
    endfunction

    // Drive one input word after its gap, hold it until accepted, then log it in the shadow.
    task automatic send_word(rrs_pkg::t_opcode op, logic [15:0] idx, logic [7:0] val);
        int gap;
        gap = draw_gap(src_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid       = 1'b1;
        in_if.opcode      = op;
        in_if.pixel_index = idx;
        in_if.pixel_value = val;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        board.take_input(op, idx, val);
        words_sent++;
    endtask

    // Ask for the next region pixel. Load its source entry first when it was never written,
    // and now and then anyway, so a write lands right before the read of the same address.
    task automatic sample_next();
        t_source src;
        src = board.trace_source();
        if (src.in_image && (!board.written[src.addr] || $urandom_range(0, 5) == 0))
            send_word(rrs_pkg::OP_WRITE, 16'(src.addr), 8'($urandom()));
        send_word(rrs_pkg::OP_SAMPLE, 16'($urandom()), 8'($urandom()));
    endtask

    // Drop valid, wait for every owed word, then let trailing writes leave the pipe.
    task automatic drain_pipe();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (board.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(rrs_pkg::t_cfg_index idx, logic [15:0] value);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        board.set_reg(idx, value);
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // Mostly legal image sizes, with zero and oversized values mixed in.
    function automatic int pick_image_dim();
        int m;
        m = $urandom_range(0, 19);
        if (m < 12) return $urandom_range(1, 256);
        if (m < 14) return 256;
        if (m == 14) return 1;
        if (m == 15) return 0;
        if (m < 18) return $urandom_range(257, 511);
        return $urandom_range(1, 16);
    endfunction

    // Center near the image most of the time, anywhere in the register range otherwise.
    function automatic int pick_center(int dim);
        int span;
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 1023)) - 512;
        span = (dim > MAX_W) ? MAX_W : dim;
        return int'($urandom_range(0, span + 16)) - 8;
    endfunction

    // Write all eight registers with a fresh setting; hand back the region area.
    task automatic pick_config(output int area);
        int w, h, rw, rh, c, s, m;
        w = pick_image_dim();
        h = pick_image_dim();

        m = $urandom_range(0, 19);
        if (m < 13) begin
            rw = $urandom_range(1, 8);
            rh = $urandom_range(1, 8);
        end else if (m < 15) begin
            // long single row or single column
            if ($urandom_range(0, 1)) begin
                rw = 256;
                rh = 1;
            end else begin
                rw = 1;
                rh = 256;
            end
        end else if (m < 17) begin
            rw = $urandom_range(0, 511);
            rh = $urandom_range(0, 511);
        end else if (m == 17) begin
            rw = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
            rh = $urandom_range(0, 3);
        end else begin
            rw = $urandom_range(9, 64);
            rh = $urandom_range(9, 64);
        end

        m = $urandom_range(0, 9);
        if (m < 6) begin
            // a true rotation: unit vector in Q14
            c = int'($urandom_range(0, 32768)) - 16384;
            s = int'($sqrt(real'(268435456 - c * c)));
            if ($urandom_range(0, 1)) s = -s;
        end else if (m == 6) begin
            c = (int'($urandom_range(0, 2)) - 1) * 16384;
            s = (int'($urandom_range(0, 2)) - 1) * 16384;
        end else begin
            c = int'($urandom_range(0, 65535)) - 32768;
            s = int'($urandom_range(0, 65535)) - 32768;
        end

        write_reg(rrs_pkg::CFG_IMAGE_WIDTH, 16'(w));
        write_reg(rrs_pkg::CFG_IMAGE_HEIGHT, 16'(h));
        write_reg(rrs_pkg::CFG_CENTER_X, 16'(pick_center(w)));
        write_reg(rrs_pkg::CFG_CENTER_Y, 16'(pick_center(h)));
        write_reg(rrs_pkg::CFG_REGION_WIDTH, 16'(rw));
        write_reg(rrs_pkg::CFG_REGION_HEIGHT, 16'(rh));
        write_reg(rrs_pkg::CFG_COS_FACTOR, 16'(c));
        write_reg(rrs_pkg::CFG_SIN_FACTOR, 16'(s));
        area = board.region_dim(9'(rw)) * board.region_dim(9'(rh));
    endtask

    // Output side: stall a random number of cycles per word, then take and check it.
    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap(snk_calm);
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            board.check_sample(out_if.sample_value, out_if.outside, out_if.last);
        end
    end

    initial begin : stimulus
        int area, n, first_random;
        board             = new();
        words_sent        = 0;
        src_calm          = 0;
        snk_calm          = 0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = rrs_pkg::CFG_IMAGE_WIDTH;
        cfg_data          = '0;
        in_if.valid       = 1'b0;
        in_if.opcode      = rrs_pkg::OP_WRITE;
        in_if.pixel_index = '0;
        in_if.pixel_value = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: the 64x64 region opens off the image corner, so these come out
        // outside. Seed the store corners with extreme values and alternating patterns.
        send_word(rrs_pkg::OP_WRITE, 16'h0000, 8'hFF);
        send_word(rrs_pkg::OP_WRITE, 16'hFFFF, 8'h00);
        send_word(rrs_pkg::OP_WRITE, 16'hAAAA, 8'h55);
        send_word(rrs_pkg::OP_WRITE, 16'h5555, 8'hAA);
        repeat (3) sample_next();
        drain_pipe();

        // Oversized width, zero height: every position outside. Region sizes of zero act
        // as one, and the counters left mid-row end the region at once.
        write_reg(rrs_pkg::CFG_IMAGE_WIDTH, 16'd511);
        write_reg(rrs_pkg::CFG_IMAGE_HEIGHT, 16'd0);
        write_reg(rrs_pkg::CFG_REGION_WIDTH, 16'd0);
        write_reg(rrs_pkg::CFG_REGION_HEIGHT, 16'd0);
        repeat (2) sample_next();
        drain_pipe();

        // One-pixel region pinned to the far corner, then the origin, then one column left
        // of the image; the factors are -1 and +1 in Q14 but the offsets are zero.
        write_reg(rrs_pkg::CFG_IMAGE_HEIGHT, 16'd257);
        write_reg(rrs_pkg::CFG_COS_FACTOR, 16'(-16384));
        write_reg(rrs_pkg::CFG_SIN_FACTOR, 16'(16384));
        write_reg(rrs_pkg::CFG_CENTER_X, 16'd255);
        write_reg(rrs_pkg::CFG_CENTER_Y, 16'd255);
        sample_next();
        drain_pipe();
        write_reg(rrs_pkg::CFG_CENTER_X, 16'd0);
        write_reg(rrs_pkg::CFG_CENTER_Y, 16'd0);
        sample_next();
        drain_pipe();
        write_reg(rrs_pkg::CFG_CENTER_X, 16'(-1));
        sample_next();
        drain_pipe();

        // Quarter turn on a 3x3 region; stop mid-region, then shrink the region below
        // the counters so they end it and wrap.
        write_reg(rrs_pkg::CFG_IMAGE_WIDTH, 16'd256);
        write_reg(rrs_pkg::CFG_IMAGE_HEIGHT, 16'd256);
        write_reg(rrs_pkg::CFG_CENTER_X, 16'd128);
        write_reg(rrs_pkg::CFG_CENTER_Y, 16'd128);
        write_reg(rrs_pkg::CFG_COS_FACTOR, 16'd0);
        write_reg(rrs_pkg::CFG_SIN_FACTOR, 16'(-16384));
        write_reg(rrs_pkg::CFG_REGION_WIDTH, 16'd3);
        write_reg(rrs_pkg::CFG_REGION_HEIGHT, 16'd3);
        repeat (4) sample_next();
        drain_pipe();
        write_reg(rrs_pkg::CFG_REGION_WIDTH, 16'd1);
        write_reg(rrs_pkg::CFG_REGION_HEIGHT, 16'd1);
        sample_next();

        // Random phases: reconfigure while idle, then walk the region with stray writes
        // between samples. Phases often stop mid-region, so the next setting inherits the
        // counters. Now and then a phase is only scattered writes.
        first_random = words_sent;
        while (words_sent < first_random + RANDOM_WORDS) begin
            drain_pipe();
            pick_config(area);
            if ($urandom_range(0, 11) == 0) begin
                repeat ($urandom_range(5, 30))
                    send_word(rrs_pkg::OP_WRITE, 16'($urandom()), 8'($urandom()));
            end else begin
                if (area <= 64)
                    n = $urandom_range(1, area + area / 2 + 2);
                else
                    n = $urandom_range(20, (area > 300) ? 150 : area + 2);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(rrs_pkg::OP_WRITE, 16'($urandom()), 8'($urandom()));
                    sample_next();
                end
            end
        end

        drain_pipe();
        if (board.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/rrs_pkg.sv
src/rrs_in_if.sv
src/rrs_out_if.sv
src/rrs_front.sv
src/rrs_queue.sv
src/rrs_back.sv
src/rotated_region_sampler_top.sv
sim/rotated_region_sampler_top_tb.sv
